// ===== hdl/pfsa_pkg.sv =====
// Package for the page frame stack allocator.
// Holds field widths, request and status codes, FSM states and the result struct.
// No dependencies.
`default_nettype none

package pfsa_pkg;

   localparam int ADDR_W          = 48;
   localparam int KIND_W          = 2;
   localparam int LEN_W           = 13;
   localparam int STAT_W          = 3;
   localparam int FREE_W          = 13;
   localparam int DEF_LIST_DEPTH  = 4096;
   localparam int DEF_FRAME_SHIFT = 21;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_FREE  = 2'd2
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NORUN     = 3'd2,
      ST_UNALIGNED = 3'd3,
      ST_ZERO      = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_POP   = 3'd1,
      S_SCAN  = 3'd2,
      S_SHIFT = 3'd3,
      S_HOLD  = 3'd4
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic [FREE_W-1:0] frames_free;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/pfsa_list_ram.sv =====
// Free frame list memory: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
`default_nettype none

module pfsa_list_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 27,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] list_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= list_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pfsa_engine.sv =====
// Request sequencer: pop, push and contiguous run scan with list compaction.
// Depends on pfsa_pkg; drives the ports of pfsa_list_ram.
`default_nettype none

module pfsa_engine import pfsa_pkg::*; #(
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH,
   parameter int FRAME_SHIFT = DEF_FRAME_SHIFT,
   localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1),
   localparam int FRAME_W = ADDR_W - FRAME_SHIFT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic [LEN_W-1:0]   req_run_length,
   input  wire logic [ADDR_W-1:0]  req_frame_address,
   output logic                    fin_valid,
   input  wire logic               fin_ready,
   output rsp_type                 fin,
   output logic                    ram_wr_en,
   output logic [IDX_W-1:0]        ram_wr_addr,
   output logic [FRAME_W-1:0]      ram_wr_data,
   output logic                    ram_rd_en,
   output logic [IDX_W-1:0]        ram_rd_addr,
   input  wire logic [FRAME_W-1:0] ram_rd_data
);

   localparam int CW = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   dst_ff, dst_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   n_ff, n_in;
   logic [FRAME_W-1:0] prev_ff, prev_in;
   logic [FRAME_W-1:0] start_ff, start_in;
   rsp_type            pend_ff, pend_in;

   rsp_type            res;
   logic               done;
   logic               pop_go;
   logic               chain;
   logic [LEN_W-1:0]   run_len;
   logic [CNT_W-1:0]   k_next;
   logic               k_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      dst_ff   <= dst_in;
      len_ff   <= len_in;
      n_ff     <= n_in;
      prev_ff  <= prev_in;
      start_ff <= start_in;
      pend_ff  <= pend_in;
   end

   assign k_next = k_ff + CNT_W'(1);
   assign k_last = (k_next == count_ff);
   assign chain  = (k_ff != '0) &&
                   ({1'b0, ram_rd_data} == ({1'b0, prev_ff} + (FRAME_W + 1)'(1)));
   assign run_len = chain ? (len_ff + LEN_W'(1)) : LEN_W'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in     = k_ff;
      dst_in   = dst_ff;
      len_in   = len_ff;
      n_in     = n_ff;
      prev_in  = prev_ff;
      start_in = start_ff;
      pend_in  = pend_ff;

      req_ready   = (state_ff == S_IDLE);
      ram_wr_en   = 1'b0;
      ram_wr_addr = dst_ff[IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = k_next[IDX_W-1:0];

      done            = 1'b0;
      pop_go          = 1'b0;
      res.address     = '0;
      res.status      = ST_OK;
      res.frames_free = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (kind_type'(req_kind))
                  KIND_ALLOC: begin
                     pop_go = 1'b1;
                  end
                  KIND_RUN: begin
                     if (req_run_length == '0) begin
                        done       = 1'b1;
                        res.status = ST_ZERO;
                     end else if (req_run_length == LEN_W'(1)) begin
                        pop_go = 1'b1;
                     end else if (CW'(req_run_length) > CW'(count_ff)) begin
                        done       = 1'b1;
                        res.status = ST_NORUN;
                     end else begin
                        n_in        = req_run_length;
                        k_in        = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  KIND_FREE: begin
                     done = 1'b1;
                     if (req_frame_address[FRAME_SHIFT-1:0] != '0) begin
                        res.status = ST_UNALIGNED;
                     end else if (count_ff == CNT_W'(LIST_DEPTH)) begin
                        res.status = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IDX_W-1:0];
                        ram_wr_data = req_frame_address[ADDR_W-1:FRAME_SHIFT];
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
               if (pop_go) begin
                  if (count_ff == '0) begin
                     done       = 1'b1;
                     res.status = ST_EMPTY;
                  end else begin
                     count_in    = count_ff - CNT_W'(1);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = count_in[IDX_W-1:0];
                     state_in    = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            done        = 1'b1;
            res.address = {ram_rd_data, {FRAME_SHIFT{1'b0}}};
         end
         S_SCAN: begin
            prev_in = ram_rd_data;
            len_in  = run_len;
            if (!chain) begin
               start_in = ram_rd_data;
            end
            if (run_len == n_ff) begin
               if (k_last) begin
                  done        = 1'b1;
                  res.address = {start_ff, {FRAME_SHIFT{1'b0}}};
                  count_in    = CNT_W'(CW'(count_ff) - CW'(n_ff));
               end else begin
                  ram_rd_en = 1'b1;
                  k_in      = k_next;
                  dst_in    = CNT_W'(CW'(k_next) - CW'(n_ff));
                  state_in  = S_SHIFT;
               end
            end else if (k_last) begin
               done       = 1'b1;
               res.status = ST_NORUN;
            end else begin
               ram_rd_en = 1'b1;
               k_in      = k_next;
            end
         end
         S_SHIFT: begin
            ram_wr_en = 1'b1;
            if (k_last) begin
               done        = 1'b1;
               res.address = {start_ff, {FRAME_SHIFT{1'b0}}};
               count_in    = CNT_W'(CW'(count_ff) - CW'(n_ff));
            end else begin
               ram_rd_en = 1'b1;
               k_in      = k_next;
               dst_in    = dst_ff + CNT_W'(1);
            end
         end
         S_HOLD: begin
            if (fin_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.frames_free = FREE_W'(count_in);

      if (done) begin
         if (fin_ready) begin
            state_in = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_HOLD;
         end
      end

      fin_valid = done || (state_ff == S_HOLD);
      fin       = (state_ff == S_HOLD) ? pend_ff : res;
   end

endmodule

`default_nettype wire

// ===== hdl/pfsa_rsp_reg.sv =====
// Result output register: holds one result transfer until the consumer takes it.
// Depends on pfsa_pkg.
`default_nettype none

module pfsa_rsp_reg import pfsa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fin_valid,
   output logic              fin_ready,
   input  wire rsp_type      fin,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [STAT_W-1:0] rsp_status,
   output logic [FREE_W-1:0] rsp_frames_free
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign fin_ready = !valid_ff || rsp_ready;
   assign valid_in  = fin_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         data_ff <= fin;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_address = data_ff.address;
   assign rsp_status         = data_ff.status;
   assign rsp_frames_free    = data_ff.frames_free;

endmodule

`default_nettype wire

// ===== hdl/page_frame_stack_allocator.sv =====
// Page frame stack allocator: top level joining sequencer, list memory and output register.
// Depends on pfsa_pkg, pfsa_list_ram, pfsa_engine and pfsa_rsp_reg.
//
// Keeps a stack of free frame numbers in one memory with one read and one write port.
// A free (kind 2) and any request that fails a check at once pass their result
// straight to the output register; a pop (kind 0, or kind 1 with length one)
// first reads the top entry through the registered read port of the memory. A
// contiguous run (kind 1) reads the list from the front, one entry a cycle, until
// the run ends or the list ends, then moves each later entry down, one entry a
// cycle. One request is in work at a time; a finished result waits in the
// output register while the next request is taken. The list needs no clearing
// after reset: the entry count marks which entries are live.
`default_nettype none

module page_frame_stack_allocator import pfsa_pkg::*; #(
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH,
   parameter int FRAME_SHIFT = DEF_FRAME_SHIFT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [LEN_W-1:0]  req_run_length,
   input  wire logic [ADDR_W-1:0] req_frame_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ADDR_W-1:0]      rsp_result_address,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [FREE_W-1:0]      rsp_frames_free
);

   localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FRAME_W = ADDR_W - FRAME_SHIFT;

   logic               fin_valid;
   logic               fin_ready;
   rsp_type            fin;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [FRAME_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [FRAME_W-1:0] ram_rd_data;

   pfsa_list_ram #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (FRAME_W)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfsa_engine #(
      .LIST_DEPTH  (LIST_DEPTH),
      .FRAME_SHIFT (FRAME_SHIFT)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_run_length    (req_run_length),
      .req_frame_address (req_frame_address),
      .fin_valid         (fin_valid),
      .fin_ready         (fin_ready),
      .fin               (fin),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   pfsa_rsp_reg u_rsp_reg (
      .clock              (clock),
      .reset              (reset),
      .fin_valid          (fin_valid),
      .fin_ready          (fin_ready),
      .fin                (fin),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_frames_free    (rsp_frames_free)
   );

endmodule

`default_nettype wire
